[rtl/sem_pkg.sv]
package sem_pkg;

    // Frame geometry.
    localparam int MAX_WIDTH    = 1024;
    localparam int COL_W        = $clog2(MAX_WIDTH);
    localparam int WIDTH_W      = 11;
    localparam int HEIGHT_W     = 13;
    localparam int HEIGHT_LIMIT = 4096;

    // Pixel and arithmetic widths.
    localparam int NUM_CH  = 3;
    localparam int CH_W    = 8;
    localparam int PIX_W   = NUM_CH * CH_W;
    localparam int GRAD_W  = 10;
    localparam int SQ_W    = 2 * GRAD_W + 1;
    localparam int ROOT_W  = CH_W;
    localparam int RAD_W   = 2 * ROOT_W;
    localparam int REM_W   = ROOT_W + 1;
    localparam int STEP_W  = $clog2(ROOT_W);

    // Squares at or above this value round to a root of 256 and saturate.
    localparam logic [SQ_W-1:0] SAT_LIMIT = SQ_W'(65281);
    localparam logic [CH_W-1:0] EDGE_MAX  = CH_W'(255);

    // Configuration register indexes.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = HEIGHT_W;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = CFG_IDX_W'(1);

    // Row store entry: the pixel one row up and the pixel of the current row.
    localparam int ROW_ENTRY_W = 2 * PIX_W;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_GRAD,
        ST_SQUARE,
        ST_ROOT,
        ST_ROUND
    } state_t;

    // One window column: top, middle and bottom pixels.
    typedef struct packed {
        logic [PIX_W-1:0] t;
        logic [PIX_W-1:0] m;
        logic [PIX_W-1:0] b;
    } column_t;

    function automatic logic [CH_W-1:0] chan_of(input logic [PIX_W-1:0] px, input int lane);
        return px[CH_W*(NUM_CH-1-lane) +: CH_W];
    endfunction

    // Weighted column sum a + 2b + c of one channel.
    function automatic logic [GRAD_W-1:0] wsum(input logic [CH_W-1:0] a,
                                               input logic [CH_W-1:0] b,
                                               input logic [CH_W-1:0] c);
        return GRAD_W'(a) + {1'b0, b, 1'b0} + GRAD_W'(c);
    endfunction

    function automatic logic [GRAD_W-1:0] abs_diff(input logic [GRAD_W-1:0] p,
                                                   input logic [GRAD_W-1:0] n);
        return (p >= n) ? (p - n) : (n - p);
    endfunction

endpackage

[rtl/sem_ram.sv]
module sem_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

[rtl/sobel_edge_magnitude_rgb.sv]
// Channel   Handshake                 Payload
// -------   -----------------------   -----------------------------------------
// in        in_valid / in_stall       kind, red, green, blue
// out       out_valid / out_stall     red_edge, green_edge, blue_edge, frame_end
// cfg       cfg_valid / cfg_ready     cfg_index, cfg_data
//
// An input beat that yields a result runs through the row store read and update and
// the gradient, square, square root and rounding steps before the block takes the
// next beat; a beat that yields no result returns to idle after the row store update.
// The square root resolves two radicand bits per cycle on each of the three channels.
// Reset clears the sequencer, the counters, the window and the output valid flag; the
// row store needs no clearing since it is only read where it was written this frame.
// A finished result sits in the output register while the next beat is accepted;
// the sequencer waits in its last step only if the previous result is still stalled.

module sobel_edge_magnitude_rgb (
    input  logic                           clk,
    input  logic                           rst_n,

    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic                           kind,
    input  logic [7:0]                     red,
    input  logic [7:0]                     green,
    input  logic [7:0]                     blue,

    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [7:0]                     red_edge,
    output logic [7:0]                     green_edge,
    output logic [7:0]                     blue_edge,
    output logic                           frame_end,

    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [sem_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [sem_pkg::CFG_DATA_W-1:0] cfg_data
);

    localparam int NCH = sem_pkg::NUM_CH;

    // Control state.
    sem_pkg::state_t                  state_reg,   state_next;
    logic [sem_pkg::WIDTH_W-1:0]      width_reg,   width_next;
    logic [sem_pkg::HEIGHT_W-1:0]     height_reg,  height_next;
    logic [sem_pkg::COL_W-1:0]        col_reg,     col_next;
    logic [sem_pkg::HEIGHT_W-1:0]     row_reg,     row_next;
    sem_pkg::column_t                 win_c_reg,   win_c_next;
    sem_pkg::column_t                 win_r_reg,   win_r_next;
    logic [sem_pkg::STEP_W-1:0]       step_reg,    step_next;
    logic                             out_valid_reg, out_valid_next;

    // Per-beat payload registers.
    logic [sem_pkg::COL_W-1:0]        cur_col_reg, cur_col_next;
    logic [sem_pkg::PIX_W-1:0]        px_reg,      px_next;
    logic                             row_ge1_reg, row_ge1_next;
    logic                             row_ge2_reg, row_ge2_next;
    logic                             restart_reg, restart_next;
    logic                             emit_reg,    emit_next;
    logic                             last_reg,    last_next;
    sem_pkg::column_t                 op_l_reg,    op_l_next;
    sem_pkg::column_t                 op_c_reg,    op_c_next;
    sem_pkg::column_t                 op_r_reg,    op_r_next;
    logic [NCH-1:0][sem_pkg::GRAD_W-1:0] ax_reg,   ax_next;
    logic [NCH-1:0][sem_pkg::GRAD_W-1:0] ay_reg,   ay_next;
    logic [NCH-1:0]                   sat_reg,     sat_next;
    logic [NCH-1:0][sem_pkg::RAD_W-1:0]  rad_reg,  rad_next;
    logic [NCH-1:0][sem_pkg::REM_W-1:0]  rem_reg,  rem_next;
    logic [NCH-1:0][sem_pkg::ROOT_W-1:0] root_reg, root_next;
    logic [NCH-1:0][sem_pkg::CH_W-1:0]   edge_reg, edge_next;
    logic                             fend_reg,    fend_next;

    // Row store port.
    logic                             ram_we;
    logic                             ram_re;
    logic [sem_pkg::COL_W-1:0]        ram_raddr;
    logic [sem_pkg::ROW_ENTRY_W-1:0]  ram_wdata;
    logic [sem_pkg::ROW_ENTRY_W-1:0]  ram_rdata;

    // Handshake terms.
    logic in_acc;
    logic out_acc;
    logic cfg_acc;

    // A pending register write takes the idle cycle, so the input beat waits for it.
    assign in_stall  = (state_reg != sem_pkg::ST_IDLE) || cfg_valid;
    assign cfg_ready = (state_reg == sem_pkg::ST_IDLE);
    assign in_acc    = in_valid && !in_stall;
    assign out_acc   = out_valid_reg && !out_stall;
    assign cfg_acc   = cfg_valid && cfg_ready;

    assign out_valid  = out_valid_reg;
    assign red_edge   = edge_reg[0];
    assign green_edge = edge_reg[1];
    assign blue_edge  = edge_reg[2];
    assign frame_end  = fend_reg;

    // The row store holds, per column, the pixel one row up (read back as the top row)
    // and the pixel of the row being written (read back as the middle row).
    sem_ram #(
        .WIDTH (sem_pkg::ROW_ENTRY_W),
        .DEPTH (sem_pkg::MAX_WIDTH)
    ) u_row_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (cur_col_reg),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        logic [sem_pkg::WIDTH_W-1:0]  w_eff;
        logic [sem_pkg::HEIGHT_W-1:0] h_eff;
        logic [sem_pkg::HEIGHT_W-1:0] h_p1;
        logic                         guard;
        logic [sem_pkg::COL_W-1:0]    c_eff;
        logic [sem_pkg::HEIGHT_W-1:0] r_eff;
        logic [sem_pkg::WIDTH_W-1:0]  col_inc;
        logic                         emit_now;
        logic                         last_now;
        logic [sem_pkg::PIX_W-1:0]    top_px;
        logic [sem_pkg::PIX_W-1:0]    mid_px;
        sem_pkg::column_t             new_col;
        sem_pkg::column_t             base_c;
        sem_pkg::column_t             base_r;
        logic                         first_col;
        logic [sem_pkg::CH_W-1:0]     lt, tc, tr, ml, mr, bl, bc, br;
        logic [2*sem_pkg::GRAD_W-1:0] sqx, sqy;
        logic [sem_pkg::SQ_W-1:0]     sq;
        logic [sem_pkg::REM_W+1:0]    rem_sh;
        logic [sem_pkg::REM_W+1:0]    trial;

        // Defaults: hold everything.
        state_next     = state_reg;
        width_next     = width_reg;
        height_next    = height_reg;
        col_next       = col_reg;
        row_next       = row_reg;
        win_c_next     = win_c_reg;
        win_r_next     = win_r_reg;
        step_next      = step_reg;
        out_valid_next = out_valid_reg;
        cur_col_next   = cur_col_reg;
        px_next        = px_reg;
        row_ge1_next   = row_ge1_reg;
        row_ge2_next   = row_ge2_reg;
        restart_next   = restart_reg;
        emit_next      = emit_reg;
        last_next      = last_reg;
        op_l_next      = op_l_reg;
        op_c_next      = op_c_reg;
        op_r_next      = op_r_reg;
        ax_next        = ax_reg;
        ay_next        = ay_reg;
        sat_next       = sat_reg;
        rad_next       = rad_reg;
        rem_next       = rem_reg;
        root_next      = root_reg;
        edge_next      = edge_reg;
        fend_next      = fend_reg;
        ram_we         = 1'b0;
        ram_re         = 1'b0;

        // Effective frame size: zero reads as one, oversize clamps to the limit.
        if (width_reg == '0)
        begin
            w_eff = sem_pkg::WIDTH_W'(1);
        end
        else if (width_reg > sem_pkg::WIDTH_W'(sem_pkg::MAX_WIDTH))
        begin
            w_eff = sem_pkg::WIDTH_W'(sem_pkg::MAX_WIDTH);
        end
        else
        begin
            w_eff = width_reg;
        end
        if (height_reg == '0)
        begin
            h_eff = sem_pkg::HEIGHT_W'(1);
        end
        else if (height_reg > sem_pkg::HEIGHT_W'(sem_pkg::HEIGHT_LIMIT))
        begin
            h_eff = sem_pkg::HEIGHT_W'(sem_pkg::HEIGHT_LIMIT);
        end
        else
        begin
            h_eff = height_reg;
        end
        h_p1 = h_eff + sem_pkg::HEIGHT_W'(1);

        // Position of the incoming beat, restarting the frame if the counters are
        // outside the frame.
        guard = (sem_pkg::WIDTH_W'(col_reg) >= w_eff) || (row_reg > h_p1);
        c_eff = guard ? '0 : col_reg;
        r_eff = guard ? '0 : row_reg;

        // A result is due from row 1, column 1 through row height+1, column 0.
        emit_now = ((r_eff >= sem_pkg::HEIGHT_W'(2))
                    || (r_eff == sem_pkg::HEIGHT_W'(1) && c_eff != '0))
                   && ((r_eff < h_p1) || (r_eff == h_p1 && c_eff == '0));
        last_now = emit_now && (r_eff == h_p1) && (c_eff == '0);
        col_inc  = sem_pkg::WIDTH_W'(c_eff) + sem_pkg::WIDTH_W'(1);

        ram_raddr = c_eff;

        top_px    = row_ge2_reg ? ram_rdata[sem_pkg::ROW_ENTRY_W-1:sem_pkg::PIX_W] : '0;
        mid_px    = row_ge1_reg ? ram_rdata[sem_pkg::PIX_W-1:0] : '0;
        ram_wdata = {mid_px, px_reg};
        new_col   = '{t: top_px, m: mid_px, b: px_reg};
        base_c    = restart_reg ? '0 : win_c_reg;
        base_r    = restart_reg ? '0 : win_r_reg;
        first_col = (cur_col_reg == '0);

        lt = '0; tc = '0; tr = '0; ml = '0; mr = '0; bl = '0; bc = '0; br = '0;
        sqx = '0; sqy = '0; sq = '0;
        rem_sh = '0; trial = '0;

        unique case (state_reg)
            sem_pkg::ST_IDLE:
            begin
                if (cfg_acc)
                begin
                    unique case (cfg_index)
                        sem_pkg::REG_WIDTH:
                        begin
                            width_next = cfg_data[sem_pkg::WIDTH_W-1:0];
                            col_next   = '0;
                            row_next   = '0;
                            win_c_next = '0;
                            win_r_next = '0;
                        end
                        sem_pkg::REG_HEIGHT:
                        begin
                            height_next = cfg_data;
                            col_next    = '0;
                            row_next    = '0;
                            win_c_next  = '0;
                            win_r_next  = '0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
                else if (in_acc)
                begin
                    ram_re       = 1'b1;
                    cur_col_next = c_eff;
                    px_next      = (!kind && r_eff < h_eff) ? {red, green, blue} : '0;
                    row_ge1_next = (r_eff >= sem_pkg::HEIGHT_W'(1));
                    row_ge2_next = (r_eff >= sem_pkg::HEIGHT_W'(2));
                    restart_next = guard;
                    emit_next    = emit_now;
                    last_next    = last_now;
                    if (last_now)
                    begin
                        col_next = '0;
                        row_next = '0;
                    end
                    else if (col_inc >= w_eff)
                    begin
                        col_next = '0;
                        row_next = r_eff + sem_pkg::HEIGHT_W'(1);
                    end
                    else
                    begin
                        col_next = col_inc[sem_pkg::COL_W-1:0];
                        row_next = r_eff;
                    end
                    state_next = sem_pkg::ST_LOAD;
                end
            end

            sem_pkg::ST_LOAD:
            begin
                // Update the row store and slide the window by one column. The first
                // column of a row sees a zero right neighbor and starts a fresh window.
                ram_we    = 1'b1;
                op_l_next = base_c;
                op_c_next = base_r;
                op_r_next = first_col ? '0 : new_col;
                if (last_reg)
                begin
                    win_c_next = '0;
                    win_r_next = '0;
                end
                else
                begin
                    win_c_next = first_col ? '0 : base_r;
                    win_r_next = new_col;
                end
                state_next = emit_reg ? sem_pkg::ST_GRAD : sem_pkg::ST_IDLE;
            end

            sem_pkg::ST_GRAD:
            begin
                for (int k = 0; k < NCH; k++)
                begin
                    lt = sem_pkg::chan_of(op_l_reg.t, k);
                    ml = sem_pkg::chan_of(op_l_reg.m, k);
                    bl = sem_pkg::chan_of(op_l_reg.b, k);
                    tc = sem_pkg::chan_of(op_c_reg.t, k);
                    bc = sem_pkg::chan_of(op_c_reg.b, k);
                    tr = sem_pkg::chan_of(op_r_reg.t, k);
                    mr = sem_pkg::chan_of(op_r_reg.m, k);
                    br = sem_pkg::chan_of(op_r_reg.b, k);
                    ax_next[k] = sem_pkg::abs_diff(sem_pkg::wsum(tr, mr, br),
                                                   sem_pkg::wsum(lt, ml, bl));
                    ay_next[k] = sem_pkg::abs_diff(sem_pkg::wsum(bl, bc, br),
                                                   sem_pkg::wsum(lt, tc, tr));
                end
                state_next = sem_pkg::ST_SQUARE;
            end

            sem_pkg::ST_SQUARE:
            begin
                for (int k = 0; k < NCH; k++)
                begin
                    sqx = ax_reg[k] * ax_reg[k];
                    sqy = ay_reg[k] * ay_reg[k];
                    sq  = sem_pkg::SQ_W'(sqx) + sem_pkg::SQ_W'(sqy);
                    sat_next[k]  = (sq >= sem_pkg::SAT_LIMIT);
                    rad_next[k]  = sq[sem_pkg::RAD_W-1:0];
                    rem_next[k]  = '0;
                    root_next[k] = '0;
                end
                step_next  = sem_pkg::STEP_W'(sem_pkg::ROOT_W - 1);
                state_next = sem_pkg::ST_ROOT;
            end

            sem_pkg::ST_ROOT:
            begin
                // One restoring square root digit per cycle on every channel.
                for (int k = 0; k < NCH; k++)
                begin
                    rem_sh = {rem_reg[k], rad_reg[k][sem_pkg::RAD_W-1 -: 2]};
                    trial  = (sem_pkg::REM_W+2)'({root_reg[k], 2'b01});
                    if (rem_sh >= trial)
                    begin
                        rem_next[k]  = sem_pkg::REM_W'(rem_sh - trial);
                        root_next[k] = {root_reg[k][sem_pkg::ROOT_W-2:0], 1'b1};
                    end
                    else
                    begin
                        rem_next[k]  = sem_pkg::REM_W'(rem_sh);
                        root_next[k] = {root_reg[k][sem_pkg::ROOT_W-2:0], 1'b0};
                    end
                    rad_next[k] = {rad_reg[k][sem_pkg::RAD_W-3:0], 2'b00};
                end
                step_next = step_reg - sem_pkg::STEP_W'(1);
                if (step_reg == '0)
                begin
                    state_next = sem_pkg::ST_ROUND;
                end
            end

            sem_pkg::ST_ROUND:
            begin
                // The remainder is x - r*r, so x > r*r + r is rem > r.
                if (!out_valid_reg || !out_stall)
                begin
                    for (int k = 0; k < NCH; k++)
                    begin
                        if (sat_reg[k])
                        begin
                            edge_next[k] = sem_pkg::EDGE_MAX;
                        end
                        else if (rem_reg[k] > sem_pkg::REM_W'(root_reg[k]))
                        begin
                            edge_next[k] = root_reg[k] + sem_pkg::CH_W'(1);
                        end
                        else
                        begin
                            edge_next[k] = root_reg[k];
                        end
                    end
                    fend_next      = last_reg;
                    out_valid_next = 1'b1;
                    state_next     = sem_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = sem_pkg::ST_IDLE;
            end
        endcase

        if (out_acc && state_reg != sem_pkg::ST_ROUND)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= sem_pkg::ST_IDLE;
            width_reg     <= sem_pkg::WIDTH_W'(640);
            height_reg    <= sem_pkg::HEIGHT_W'(480);
            col_reg       <= '0;
            row_reg       <= '0;
            win_c_reg     <= '0;
            win_r_reg     <= '0;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            width_reg     <= width_next;
            height_reg    <= height_next;
            col_reg       <= col_next;
            row_reg       <= row_next;
            win_c_reg     <= win_c_next;
            win_r_reg     <= win_r_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_col_reg <= cur_col_next;
        px_reg      <= px_next;
        row_ge1_reg <= row_ge1_next;
        row_ge2_reg <= row_ge2_next;
        restart_reg <= restart_next;
        emit_reg    <= emit_next;
        last_reg    <= last_next;
        op_l_reg    <= op_l_next;
        op_c_reg    <= op_c_next;
        op_r_reg    <= op_r_next;
        ax_reg      <= ax_next;
        ay_reg      <= ay_next;
        sat_reg     <= sat_next;
        rad_reg     <= rad_next;
        rem_reg     <= rem_next;
        root_reg    <= root_next;
        edge_reg    <= edge_next;
        fend_reg    <= fend_next;
    end

    // An accepted beat always goes to the row store update next.
    a_accept_to_load: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |=> state_reg == sem_pkg::ST_LOAD)
        else $error("accepted beat did not start the row store update");

    // A finished result waits while the previous one is still held.
    a_round_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == sem_pkg::ST_ROUND && out_valid_reg && out_stall)
        |=> (state_reg == sem_pkg::ST_ROUND && out_valid_reg))
        else $error("pending result overwrote a stalled one");

    // The root runs exactly through its last digit and then rounds.
    a_root_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == sem_pkg::ST_ROOT && step_reg == '0) |=> state_reg == sem_pkg::ST_ROUND)
        else $error("square root did not finish after its last digit");

    // After the last digit the red channel's remainder never exceeds twice its root.
    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == sem_pkg::ST_ROUND |-> rem_reg[0] <= {root_reg[0], 1'b0})
        else $error("square root remainder out of range");

    // The beat that ends the frame leaves the counters at the frame start.
    a_frame_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != sem_pkg::ST_IDLE && last_reg) |-> (col_reg == '0 && row_reg == '0))
        else $error("frame end did not restart the counters");

endmodule
